FILE: sv/pcb_pool_ready_queue_macros.svh
// Assertion macros for the process control block pool.
`ifndef PCB_POOL_READY_QUEUE_MACROS_SVH
`define PCB_POOL_READY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define PCBQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcbq assertion failed");
`define PCBQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcbq assertion failed");
`else
`define PCBQ_ASSERT_SAME(label, ante, cons)
`define PCBQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/pcbq_pkg.sv
package pcbq_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int ID_WIDTH_DEF   = 16;
  localparam logic [7:0] TIME_SLICE_RESET = 8'd5;

  typedef enum logic {
    OP_CREATE   = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_NO_FREE = 2'd1,
    RS_EMPTY   = 2'd2
  } res_status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SCHED = 1'b1
  } fsm_state_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] process_id;
  } in_item_t;

  typedef struct packed {
    res_status_t result_status;
    logic [3:0]  slot;
    logic [15:0] name_out;
    logic [15:0] reg_a;
    logic [15:0] reg_b;
    logic [15:0] reg_c;
    logic [15:0] reg_d;
    logic [15:0] prog_counter;
    logic [15:0] status_word;
    logic [7:0]  timer_load;
  } out_item_t;

endpackage

FILE: sv/pcb_pool_ready_queue.sv
// Process control block pool with a FIFO ready queue. A create request takes the next
// free block, stores the process id as its name and saved context and appends it to the
// ready queue; its registered result is ready in the cycle after acceptance. A schedule
// request pops the queue head and returns its name, context and the configured time slice;
// the name and link memories have a registered read port, so the result is built from that
// read in the S_SCHED state and then registered. The block handles one request at a time.
// Blocks that have been dispatched are never returned to the pool. The time slice register
// may be written at any time and takes effect on the next dispatch.
`include "pcb_pool_ready_queue_macros.svh"

module pcb_pool_ready_queue
  import pcbq_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  fsm_state_t state_r, state_nxt;

  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic [7:0]       time_slice_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [ID_WIDTH-1:0] name_mem [NUM_BLOCKS];
  logic [IDX_W-1:0]    link_mem [NUM_BLOCKS];
  logic [ID_WIDTH-1:0] name_rd_r;
  logic [IDX_W-1:0]    link_rd_r;

  logic             accept;
  logic             is_create;
  logic             has_free;
  logic             create_ok;
  logic             rd_en;
  logic             sched_empty;
  logic             link_we;
  logic [IDX_W-1:0] free_idx;
  logic [ID_WIDTH-1:0] new_id;
  logic [15:0]      ctx_word;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept      = in_valid && in_ready;
  assign is_create   = accept && (in_data.opcode == OP_CREATE);
  assign has_free    = free_cnt_r < CNT_W'(NUM_BLOCKS);
  assign create_ok   = is_create && has_free;
  assign rd_en       = accept && (in_data.opcode == OP_SCHEDULE) && nonempty_r;
  assign sched_empty = accept && (in_data.opcode == OP_SCHEDULE) && !nonempty_r;
  assign link_we     = create_ok && nonempty_r;
  assign free_idx    = free_cnt_r[IDX_W-1:0];
  assign new_id      = ID_WIDTH'(in_data.process_id);
  assign ctx_word    = 16'(name_rd_r);

  always_ff @(posedge clk) begin
    if (create_ok) begin
      name_mem[free_idx] <= new_id;
    end
    if (rd_en) begin
      name_rd_r <= name_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[tail_r] <= free_idx;
    end
    if (rd_en) begin
      link_rd_r <= link_mem[head_r];
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = rd_en ? S_SCHED : S_IDLE;
      S_SCHED: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    free_cnt_nxt  = free_cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    nonempty_nxt  = nonempty_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          if (in_data.opcode == OP_CREATE) begin
            out_valid_nxt = 1'b1;
            if (has_free) begin
              out_data_nxt.result_status = RS_OK;
              out_data_nxt.slot          = 4'(free_idx);
              free_cnt_nxt = free_cnt_r + CNT_W'(1);
              tail_nxt     = free_idx;
              nonempty_nxt = 1'b1;
              if (!nonempty_r) begin
                head_nxt = free_idx;
              end
            end else begin
              out_data_nxt.result_status = RS_NO_FREE;
            end
          end else if (sched_empty) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.result_status = RS_EMPTY;
          end
        end
      end
      S_SCHED: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.result_status = RS_OK;
        out_data_nxt.slot          = 4'(head_r);
        out_data_nxt.name_out      = ctx_word;
        out_data_nxt.reg_a         = ctx_word;
        out_data_nxt.reg_b         = ctx_word;
        out_data_nxt.reg_c         = ctx_word;
        out_data_nxt.reg_d         = ctx_word;
        out_data_nxt.prog_counter  = ctx_word;
        out_data_nxt.status_word   = ctx_word;
        out_data_nxt.timer_load    = time_slice_r;
        if (head_r == tail_r) begin
          nonempty_nxt = 1'b0;
        end else begin
          head_nxt = link_rd_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_cnt_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      nonempty_r   <= 1'b0;
      time_slice_r <= TIME_SLICE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        time_slice_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `PCBQ_ASSERT_SAME(a_no_accept_in_sched, state_r == S_SCHED, !in_ready)
  `PCBQ_ASSERT_NEXT(a_sched_gives_result, state_r == S_SCHED, out_valid_r)
  `PCBQ_ASSERT_SAME(a_free_cnt_range, 1'b1, free_cnt_r <= CNT_W'(NUM_BLOCKS))
  `PCBQ_ASSERT_NEXT(a_empty_out, sched_empty, out_valid_r && out_data_r.result_status == RS_EMPTY)

endmodule

FILE: bench/pcb_pool_ready_queue_check.sv
module pcb_pool_ready_queue_check
  import pcbq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [7:0] cfg_data,
  output int        mismatches,
  output int        awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = NUM_BLOCKS_DEF;
  localparam int CTX_WORDS = 6;
  localparam int REPORT_LIMIT = 10;

  typedef logic [3:0] slot_t;

  logic [7:0]  slice;
  logic [15:0] pcb_name [POOL];
  logic [15:0] pcb_ctx [POOL][CTX_WORDS];
  slot_t       pcb_next [POOL];
  logic        pcb_next_ok [POOL];
  slot_t       free_head;
  logic        free_ok;
  slot_t       ready_head;
  slot_t       ready_tail;
  logic        ready_ok;

  out_item_t   awaited_results [$];

  // Applies one request to the pool and queue, returning the result it must produce.
  function automatic out_item_t pool_outcome(in_item_t req);
    out_item_t res;
    slot_t     s;
    int        k;
    res = '0;
    if (req.opcode == OP_CREATE) begin
      if (!free_ok) begin
        res.result_status = RS_NO_FREE;
      end else begin
        s = free_head;
        free_ok = pcb_next_ok[s];
        free_head = pcb_next[s];
        pcb_name[s] = req.process_id;
        for (k = 0; k < CTX_WORDS; k++) pcb_ctx[s][k] = req.process_id;
        if (ready_ok) begin
          pcb_next[ready_tail] = s;
          pcb_next_ok[ready_tail] = 1'b1;
        end else begin
          ready_head = s;
          ready_ok = 1'b1;
        end
        ready_tail = s;
        pcb_next[s] = '0;
        pcb_next_ok[s] = 1'b0;
        res.result_status = RS_OK;
        res.slot = s;
      end
    end else if (!ready_ok) begin
      res.result_status = RS_EMPTY;
    end else begin
      s = ready_head;
      ready_ok = pcb_next_ok[s];
      ready_head = pcb_next[s];
      pcb_next[s] = '0;
      pcb_next_ok[s] = 1'b0;
      res.result_status = RS_OK;
      res.slot = s;
      res.name_out = pcb_name[s];
      res.reg_a = pcb_ctx[s][0];
      res.reg_b = pcb_ctx[s][1];
      res.reg_c = pcb_ctx[s][2];
      res.reg_d = pcb_ctx[s][3];
      res.prog_counter = pcb_ctx[s][4];
      res.status_word = pcb_ctx[s][5];
      res.timer_load = slice;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    string     diffs;
    int        i;
    if (!rst_n) begin
      slice = TIME_SLICE_RESET;
      for (i = 0; i < POOL; i++) begin
        pcb_next[i] = slot_t'(i + 1);
        pcb_next_ok[i] = (i + 1 < POOL);
      end
      free_head = '0;
      free_ok = 1'b1;
      ready_head = '0;
      ready_tail = '0;
      ready_ok = 1'b0;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) slice = cfg_data;
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: result with no request outstanding: %h", $realtime, out_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          diffs = "";
          if (out_data.result_status !== want.result_status)
            diffs = {diffs, $sformatf(" status exp %0d got %0d", want.result_status,
                                      out_data.result_status)};
          if (out_data.slot !== want.slot)
            diffs = {diffs, $sformatf(" slot exp %0d got %0d", want.slot, out_data.slot)};
          if (out_data.name_out !== want.name_out)
            diffs = {diffs, $sformatf(" name exp %h got %h", want.name_out, out_data.name_out)};
          if (out_data.reg_a !== want.reg_a)
            diffs = {diffs, $sformatf(" reg_a exp %h got %h", want.reg_a, out_data.reg_a)};
          if (out_data.reg_b !== want.reg_b)
            diffs = {diffs, $sformatf(" reg_b exp %h got %h", want.reg_b, out_data.reg_b)};
          if (out_data.reg_c !== want.reg_c)
            diffs = {diffs, $sformatf(" reg_c exp %h got %h", want.reg_c, out_data.reg_c)};
          if (out_data.reg_d !== want.reg_d)
            diffs = {diffs, $sformatf(" reg_d exp %h got %h", want.reg_d, out_data.reg_d)};
          if (out_data.prog_counter !== want.prog_counter)
            diffs = {diffs, $sformatf(" pc exp %h got %h", want.prog_counter,
                                      out_data.prog_counter)};
          if (out_data.status_word !== want.status_word)
            diffs = {diffs, $sformatf(" psw exp %h got %h", want.status_word,
                                      out_data.status_word)};
          if (out_data.timer_load !== want.timer_load)
            diffs = {diffs, $sformatf(" timer exp %0d got %0d", want.timer_load,
                                      out_data.timer_load)};
          if (diffs != "") begin
            if (mismatches < REPORT_LIMIT) $display("%0t: result mismatch:%s", $realtime, diffs);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(pool_outcome(in_data));
    end
    awaiting = awaited_results.size();
  end

endmodule

FILE: bench/pcb_pool_ready_queue_test.sv
module pcb_pool_ready_queue_test
  import pcbq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1130;
  localparam int MAX_GAP = 12;
  localparam int LONG_HOLD = 80;
  localparam int HOLD_AFTER = 200;
  localparam int QUIET_LIMIT = 1000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  int mismatches;
  int awaiting;
  int requests_sent = 0;
  int results_seen = 0;
  int creates_sent = 0;
  int schedules_sent = 0;
  int slice_writes = 0;
  int quiet = 0;
  logic tx_eager = 1'b0;
  logic rx_eager = 1'b0;

  pcb_pool_ready_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pcb_pool_ready_queue_check u_pool_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen <= results_seen + 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles without a request or result moving.", quiet);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_request(input op_t op, input logic [15:0] id);
    in_item_t req;
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    req.opcode = op;
    req.process_id = id;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (op == OP_CREATE) creates_sent++;
    else schedules_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slice(input logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slice_writes++;
  endtask

  initial begin
    int gap;
    logic held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (!held && results_seen >= HOLD_AFTER) begin
        gap = LONG_HOLD;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int n;
    int phase;
    int len;
    int sent_random;
    logic [7:0] value;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The pool starts with an empty ready queue, so the first schedule must fail.
    send_request(OP_SCHEDULE, 16'($urandom));
    send_request(OP_CREATE, 16'h0000);
    send_request(OP_CREATE, 16'hFFFF);
    send_request(OP_SCHEDULE, 16'($urandom));
    send_request(OP_SCHEDULE, 16'($urandom));
    send_request(OP_SCHEDULE, 16'($urandom));

    write_slice(8'd0);
    send_request(OP_CREATE, 16'h5555);
    send_request(OP_CREATE, 16'hAAAA);
    send_request(OP_SCHEDULE, 16'h0000);
    send_request(OP_SCHEDULE, 16'hFFFF);

    write_slice(8'd255);
    send_request(OP_CREATE, 16'($urandom));
    send_request(OP_SCHEDULE, 16'($urandom));

    // Use up the rest of the pool and then ask for one more block.
    write_slice(8'd1);
    for (n = 0; n < 11; n++) send_request(OP_CREATE, 16'($urandom));
    send_request(OP_CREATE, 16'hFFFF);

    sent_random = 0;
    phase = 0;
    while (sent_random < RANDOM_REQUESTS) begin
      case (phase % 3)
        0: value = 8'($urandom_range(0, 255));
        1: value = 8'd255;
        default: value = 8'd1;
      endcase
      write_slice(value);
      len = (phase < 5) ? 4 : 250;
      for (n = 0; n < len && sent_random < RANDOM_REQUESTS; n++) begin
        if (n % 40 == 0) begin
          tx_eager = ($urandom_range(0, 2) == 0);
          rx_eager = ($urandom_range(0, 2) == 0);
        end
        send_request(op_t'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)));
        sent_random++;
      end
      phase++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d create and %0d schedule requests over %0d time slice settings.",
             creates_sent, schedules_sent, slice_writes);
    $display("Checked %0d results, including pool exhaustion and empty-queue cases.",
             results_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results still outstanding.", mismatches, awaiting);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
